[rtl/psat_pkg.sv]
// Package for the polygon separating-axis test unit.
// Item types, kind codes and widths; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package psat_pkg;

   localparam int COORD_BITS = 16;
   localparam int DOT_BITS   = 2 * COORD_BITS + 1;
   localparam int MAX_AXES   = 16;

   localparam logic [1:0] KIND_NORMAL = 2'd0;
   localparam logic [1:0] KIND_FIRST  = 2'd1;
   localparam logic [1:0] KIND_SECOND = 2'd2;
   localparam logic [1:0] KIND_FINISH = 2'd3;

   typedef struct packed {
      logic [1:0]                   kind;
      logic signed [COORD_BITS-1:0] coord_x;
      logic signed [COORD_BITS-1:0] coord_y;
   } req_type;

   typedef struct packed {
      logic collide;
      logic normals_dropped;
   } rsp_type;

   typedef struct packed {
      logic prod_valid;
      logic sum_valid;
   } dot_status_type;

endpackage
`default_nettype wire

[rtl/psat_dot.sv]
// Two-stage dot product unit: product pair, then exact sum.
// Depends on psat_pkg.
`timescale 1ns / 1ps
`default_nettype none
module psat_dot (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    in_valid,
   input  wire logic signed [psat_pkg::COORD_BITS-1:0] ax,
   input  wire logic signed [psat_pkg::COORD_BITS-1:0] ay,
   input  wire logic signed [psat_pkg::COORD_BITS-1:0] bx,
   input  wire logic signed [psat_pkg::COORD_BITS-1:0] by,
   output psat_pkg::dot_status_type                     status,
   output logic signed [psat_pkg::DOT_BITS-1:0]         sum
);

   localparam int ProdBits = 2 * psat_pkg::COORD_BITS;

   logic signed [ProdBits-1:0]           prod_x_ff, prod_y_ff;
   logic signed [psat_pkg::DOT_BITS-1:0] sum_ff;
   logic                                 prod_valid_ff, sum_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= in_valid;
         sum_valid_ff  <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_x_ff <= ax * bx;
      prod_y_ff <= ay * by;
      sum_ff    <= {prod_x_ff[ProdBits-1], prod_x_ff} + {prod_y_ff[ProdBits-1], prod_y_ff};
   end

   assign status.prod_valid = prod_valid_ff;
   assign status.sum_valid  = sum_valid_ff;
   assign sum               = sum_ff;

endmodule
`default_nettype wire

[rtl/polygon_separating_axis_test_unit.sv]
// Top level of the polygon separating-axis test unit.
// Depends on psat_pkg and psat_dot.
//
// Usage: items enter on req_data, taken when start is high and busy low.
// A normal item stores an axis; normals after any point, or beyond MAX_AXES,
// are dropped and flagged. A point item is projected onto each stored axis,
// one axis per cycle through the shared multiplier pair, then bounds are
// updated through the multiply, sum and bound read-modify-write pipeline.
// A finish item scans the stored bounds one axis per cycle when both
// polygons have points. Its result item appears on rsp_data with rsp_valid
// high for one cycle, in the same cycle that busy falls, and the store is
// cleared. Point and normal items give no result. The receiver cannot stall:
// the result is presented once and must be taken. Synchronous reset empties
// the axis store and clears the seen, drop and separation flags; no clearing
// pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module polygon_separating_axis_test_unit #(
   parameter int MAX_AXES = psat_pkg::MAX_AXES
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire psat_pkg::req_type req_data,
   output logic                   rsp_valid,
   output psat_pkg::rsp_type      rsp_data
);

   localparam int CB     = psat_pkg::COORD_BITS;
   localparam int DB     = psat_pkg::DOT_BITS;
   localparam int CNT_W  = $clog2(MAX_AXES + 1);
   localparam int IDX_W  = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROJ,
      ST_EVAL
   } state_type;

   state_type            state_ff;
   logic [CNT_W-1:0]     count_ff, idx_ff;
   logic                 first_seen_ff, second_seen_ff, drop_ff;
   logic                 second_ff, fresh_ff, apart_ff;
   logic                 v1_ff;
   logic [IDX_W-1:0]     idx1_ff, idx2_ff, idx3_ff;
   logic signed [CB-1:0] px_ff, py_ff;
   logic                 rsp_valid_ff;
   psat_pkg::rsp_type    rsp_data_ff;

   logic signed [CB-1:0] axis_x_mem [MAX_AXES];
   logic signed [CB-1:0] axis_y_mem [MAX_AXES];
   logic signed [DB-1:0] first_min_mem  [MAX_AXES];
   logic signed [DB-1:0] first_max_mem  [MAX_AXES];
   logic signed [DB-1:0] second_min_mem [MAX_AXES];
   logic signed [DB-1:0] second_max_mem [MAX_AXES];

   logic signed [CB-1:0] ax_rd_ff, ay_rd_ff;
   logic signed [DB-1:0] fmin_rd_ff, fmax_rd_ff, smin_rd_ff, smax_rd_ff;

   psat_pkg::dot_status_type dot_status;
   logic signed [DB-1:0]     dot_sum;

   logic                 accept, both_seen, issue, axis_wr, bound_wr;
   logic [IDX_W-1:0]     axis_rd_addr, bound_rd_addr;
   logic signed [DB-1:0] lo_cur, hi_cur, lo_new, hi_new;
   logic                 proj_done, eval_done, sep_final;

   assign accept    = start && !busy;
   assign both_seen = first_seen_ff && second_seen_ff;
   assign busy      = (state_ff != ST_IDLE);

   assign issue = ((state_ff == ST_PROJ) || ((state_ff == ST_EVAL) && both_seen))
                  && (idx_ff < count_ff);
   assign axis_rd_addr  = idx_ff[IDX_W-1:0];
   assign bound_rd_addr = (state_ff == ST_EVAL) ? idx_ff[IDX_W-1:0] : idx2_ff;

   assign axis_wr = accept && (req_data.kind == psat_pkg::KIND_NORMAL)
                    && !first_seen_ff && !second_seen_ff
                    && (count_ff < CNT_W'(MAX_AXES));

   // bound read-modify-write, last pipeline stage
   assign lo_cur   = second_ff ? smin_rd_ff : fmin_rd_ff;
   assign hi_cur   = second_ff ? smax_rd_ff : fmax_rd_ff;
   assign lo_new   = (fresh_ff || (dot_sum < lo_cur)) ? dot_sum : lo_cur;
   assign hi_new   = (fresh_ff || (dot_sum > hi_cur)) ? dot_sum : hi_cur;
   assign bound_wr = (state_ff == ST_PROJ) && dot_status.sum_valid;

   assign proj_done = (idx_ff == count_ff) && !v1_ff
                      && !dot_status.prod_valid && !dot_status.sum_valid;
   assign eval_done = (!both_seen || (idx_ff == count_ff)) && !v1_ff;
   assign sep_final = both_seen ? apart_ff
                                : (first_seen_ff && (count_ff != '0));

   psat_dot u_dot (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v1_ff && (state_ff == ST_PROJ)),
      .ax       (px_ff),
      .ay       (py_ff),
      .bx       (ax_rd_ff),
      .by       (ay_rd_ff),
      .status   (dot_status),
      .sum      (dot_sum)
   );

   always_ff @(posedge clock) begin
      if (axis_wr) begin
         axis_x_mem[count_ff[IDX_W-1:0]] <= req_data.coord_x;
         axis_y_mem[count_ff[IDX_W-1:0]] <= req_data.coord_y;
      end
      ax_rd_ff <= axis_x_mem[axis_rd_addr];
      ay_rd_ff <= axis_y_mem[axis_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (bound_wr && !second_ff) begin
         first_min_mem[idx3_ff] <= lo_new;
         first_max_mem[idx3_ff] <= hi_new;
      end
      if (bound_wr && second_ff) begin
         second_min_mem[idx3_ff] <= lo_new;
         second_max_mem[idx3_ff] <= hi_new;
      end
      fmin_rd_ff <= first_min_mem[bound_rd_addr];
      fmax_rd_ff <= first_max_mem[bound_rd_addr];
      smin_rd_ff <= second_min_mem[bound_rd_addr];
      smax_rd_ff <= second_max_mem[bound_rd_addr];
   end

   // index pipeline alongside the dot unit
   always_ff @(posedge clock) begin
      idx1_ff <= idx_ff[IDX_W-1:0];
      idx2_ff <= idx1_ff;
      idx3_ff <= idx2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         idx_ff         <= '0;
         first_seen_ff  <= 1'b0;
         second_seen_ff <= 1'b0;
         drop_ff        <= 1'b0;
         apart_ff       <= 1'b0;
         v1_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         v1_ff        <= issue;
         if (issue) begin
            idx_ff <= idx_ff + CNT_W'(1);
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  idx_ff   <= '0;
                  apart_ff <= 1'b0;
                  case (req_data.kind)
                     psat_pkg::KIND_NORMAL: begin
                        if (axis_wr) begin
                           count_ff <= count_ff + CNT_W'(1);
                        end else begin
                           drop_ff <= 1'b1;
                        end
                     end
                     psat_pkg::KIND_FIRST: begin
                        second_ff <= 1'b0;
                        fresh_ff  <= !first_seen_ff;
                        state_ff  <= ST_PROJ;
                     end
                     psat_pkg::KIND_SECOND: begin
                        second_ff <= 1'b1;
                        fresh_ff  <= !second_seen_ff;
                        state_ff  <= ST_PROJ;
                     end
                     default: begin
                        state_ff <= ST_EVAL;
                     end
                  endcase
                  px_ff <= req_data.coord_x;
                  py_ff <= req_data.coord_y;
               end
            end
            ST_PROJ: begin
               if (proj_done) begin
                  if (second_ff) begin
                     second_seen_ff <= 1'b1;
                  end else begin
                     first_seen_ff <= 1'b1;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            ST_EVAL: begin
               if (v1_ff && ((fmax_rd_ff < smin_rd_ff) || (fmin_rd_ff > smax_rd_ff))) begin
                  apart_ff <= 1'b1;
               end
               if (eval_done) begin
                  rsp_valid_ff                <= 1'b1;
                  rsp_data_ff.collide         <= !sep_final;
                  rsp_data_ff.normals_dropped <= drop_ff;
                  count_ff                    <= '0;
                  first_seen_ff               <= 1'b0;
                  second_seen_ff              <= 1'b0;
                  drop_ff                     <= 1'b0;
                  state_ff                    <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

[verif/polygon_separating_axis_test_unit_tb.sv]
// Testbench for polygon_separating_axis_test_unit: a directed table, then axis/point/finish
// sequences with random content, checked against an in-bench overlap predictor, or against
// the tabled result for typed rows. Depends on psat_pkg and the RTL top level.
`timescale 1ns / 1ps
module polygon_separating_axis_test_unit_tb;

   typedef struct {
      psat_pkg::req_type item;
      bit                typed;
      psat_pkg::rsp_type want;
   } stim_row_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   psat_pkg::req_type req_data;
   logic              rsp_valid;
   psat_pkg::rsp_type rsp_data;

   // predictor state
   longint axis_x [psat_pkg::MAX_AXES];
   longint axis_y [psat_pkg::MAX_AXES];
   int     axis_total;
   longint one_lo [psat_pkg::MAX_AXES];
   longint one_hi [psat_pkg::MAX_AXES];
   longint two_lo [psat_pkg::MAX_AXES];
   longint two_hi [psat_pkg::MAX_AXES];
   bit     one_seen;
   bit     two_seen;
   bit     axis_dropped;

   psat_pkg::rsp_type pending_verdicts[$];
   stim_row_type      directed_rows[$];
   int                error_count;
   int                items_accepted;
   int                verdicts_checked;
   int                collide_count;
   int                dropped_count;
   int                sequence_count;

   polygon_separating_axis_test_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   task automatic report_mismatch(input string what, input int want, input int got);
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
      error_count++;
   endtask

   function automatic bit predict_overlap_item(input psat_pkg::req_type it,
                                               output psat_pkg::rsp_type verdict);
      longint m;
      bit     apart;
      bit     gives;
      verdict = '0;
      gives = 1'b0;
      case (it.kind)
         psat_pkg::KIND_NORMAL: begin
            if (one_seen || two_seen || axis_total >= psat_pkg::MAX_AXES) begin
               axis_dropped = 1'b1;
            end else begin
               axis_x[axis_total] = longint'(it.coord_x);
               axis_y[axis_total] = longint'(it.coord_y);
               axis_total++;
            end
         end
         psat_pkg::KIND_FIRST, psat_pkg::KIND_SECOND: begin
            for (int i = 0; i < axis_total; i++) begin
               m = longint'(it.coord_x) * axis_x[i] + longint'(it.coord_y) * axis_y[i];
               if (it.kind == psat_pkg::KIND_SECOND) begin
                  if (!two_seen || m < two_lo[i]) two_lo[i] = m;
                  if (!two_seen || m > two_hi[i]) two_hi[i] = m;
               end else begin
                  if (!one_seen || m < one_lo[i]) one_lo[i] = m;
                  if (!one_seen || m > one_hi[i]) one_hi[i] = m;
               end
            end
            if (it.kind == psat_pkg::KIND_SECOND) two_seen = 1'b1;
            else one_seen = 1'b1;
         end
         default: begin
            verdict.collide = 1'b1;
            for (int i = 0; i < axis_total; i++) begin
               if (one_seen && two_seen)
                  apart = one_hi[i] < two_lo[i] || one_lo[i] > two_hi[i];
               else
                  apart = one_seen && !two_seen;
               if (apart) verdict.collide = 1'b0;
            end
            verdict.normals_dropped = axis_dropped;
            axis_total = 0;
            one_seen = 1'b0;
            two_seen = 1'b0;
            axis_dropped = 1'b0;
            gives = 1'b1;
         end
      endcase
      return gives;
   endfunction

   task automatic drive_item(input psat_pkg::req_type it, input bit typed,
                             input psat_pkg::rsp_type want);
      psat_pkg::rsp_type predicted;
      bit                ok;
      int                idle_pct;
      idle_pct = (items_accepted >= 250 && items_accepted < 400) ? 0 : 23;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= it;
      ok = 1'b0;
      while (!ok) begin
         @(negedge clock);
         ok = !busy;
         @(posedge clock);
      end
      items_accepted++;
      if (predict_overlap_item(it, predicted))
         pending_verdicts.push_back(typed ? want : predicted);
   endtask

   function automatic void add_row(input logic [1:0] kind, input int x, input int y,
                                   input int typed, input int collide, input int dropped);
      stim_row_type r;
      r.item.kind = kind;
      r.item.coord_x = 16'(x);
      r.item.coord_y = 16'(y);
      r.typed = (typed != 0);
      r.want.collide = (collide != 0);
      r.want.normals_dropped = (dropped != 0);
      directed_rows.push_back(r);
   endfunction

   function automatic logic signed [15:0] rand_coord(input int mode);
      logic signed [15:0] c;
      case (mode)
         0: c = 16'($urandom);
         1: c = 16'(int'($urandom_range(16)) - 8);
         default: begin
            case ($urandom_range(5))
               0: c = -16'sd32768;
               1: c = -16'sd32767;
               2: c = -16'sd1;
               3: c = 16'sd0;
               4: c = 16'sd1;
               default: c = 16'sd32767;
            endcase
         end
      endcase
      return c;
   endfunction

   task automatic run_sequence(input bit force_excess);
      psat_pkg::req_type it;
      int                mode;
      int                pick;
      int                n_axes;
      int                n_points;
      int                off_x;
      int                off_y;
      bit                skip_one;
      bit                skip_two;
      pick = $urandom_range(99);
      mode = pick < 30 ? 0 : (pick < 85 ? 1 : 2);
      pick = $urandom_range(99);
      if (force_excess) n_axes = psat_pkg::MAX_AXES + 2;
      else if (pick < 5) n_axes = 0;
      else if (pick < 15) n_axes = $urandom_range(psat_pkg::MAX_AXES, 5);
      else if (pick < 22) n_axes = psat_pkg::MAX_AXES + $urandom_range(3, 1);
      else n_axes = $urandom_range(4, 1);
      for (int i = 0; i < n_axes; i++) begin
         it.kind = psat_pkg::KIND_NORMAL;
         it.coord_x = rand_coord(mode);
         it.coord_y = rand_coord(mode);
         drive_item(it, 1'b0, '0);
      end
      skip_one = $urandom_range(9) == 0;
      skip_two = !skip_one && $urandom_range(9) == 0;
      off_x = int'($urandom_range(12)) - 6;
      off_y = int'($urandom_range(12)) - 6;
      n_points = $urandom_range(8);
      for (int i = 0; i < n_points; i++) begin
         if ($urandom_range(99) < 8) begin
            // late axis, dropped once a point has been taken
            it.kind = psat_pkg::KIND_NORMAL;
            it.coord_x = rand_coord(mode);
            it.coord_y = rand_coord(mode);
            drive_item(it, 1'b0, '0);
         end
         if (skip_two || (!skip_one && $urandom_range(1) == 0)) begin
            it.kind = psat_pkg::KIND_FIRST;
            it.coord_x = rand_coord(mode);
            it.coord_y = rand_coord(mode);
         end else begin
            it.kind = psat_pkg::KIND_SECOND;
            it.coord_x = rand_coord(mode) + off_x[15:0];
            it.coord_y = rand_coord(mode) + off_y[15:0];
         end
         drive_item(it, 1'b0, '0);
      end
      it.kind = psat_pkg::KIND_FINISH;
      it.coord_x = 16'($urandom);
      it.coord_y = 16'($urandom);
      drive_item(it, 1'b0, '0);
      sequence_count++;
   endtask

   task automatic send_noise();
      psat_pkg::req_type it;
      int                n;
      n = $urandom_range(6, 1);
      for (int i = 0; i < n; i++) begin
         it.kind = 2'($urandom_range(3));
         it.coord_x = 16'($urandom);
         it.coord_y = 16'($urandom);
         drive_item(it, 1'b0, '0);
      end
   endtask

   always @(negedge clock) begin
      psat_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_verdicts.size() == 0) begin
            $display("[%0t] result item with nothing expected", $realtime);
            error_count++;
         end else begin
            want = pending_verdicts.pop_front();
            verdicts_checked++;
            if (rsp_data.collide !== want.collide)
               report_mismatch("collide", int'(want.collide), int'(rsp_data.collide));
            if (rsp_data.normals_dropped !== want.normals_dropped)
               report_mismatch("normals_dropped", int'(want.normals_dropped),
                               int'(rsp_data.normals_dropped));
            if (want.collide) collide_count++;
            if (want.normals_dropped) dropped_count++;
         end
      end
   end

   initial begin
      int guard;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      error_count = 0;
      items_accepted = 0;
      verdicts_checked = 0;
      collide_count = 0;
      dropped_count = 0;
      sequence_count = 0;
      axis_total = 0;
      one_seen = 1'b0;
      two_seen = 1'b0;
      axis_dropped = 1'b0;

      // finish straight after reset: no axes
      add_row(psat_pkg::KIND_FINISH, 0, 0, 1, 1, 0);
      // extreme points split on the x axis
      add_row(psat_pkg::KIND_NORMAL, 1, 0, 0, 0, 0);
      add_row(psat_pkg::KIND_FIRST, -32768, -32768, 0, 0, 0);
      add_row(psat_pkg::KIND_SECOND, 32767, 32767, 0, 0, 0);
      add_row(psat_pkg::KIND_FINISH, 0, 0, 1, 0, 0);
      // zero axis, extreme axis, late normal
      add_row(psat_pkg::KIND_NORMAL, 0, 0, 0, 0, 0);
      add_row(psat_pkg::KIND_NORMAL, -32768, 32767, 0, 0, 0);
      add_row(psat_pkg::KIND_FIRST, 32767, -32768, 0, 0, 0);
      add_row(psat_pkg::KIND_NORMAL, 5, 5, 0, 0, 0);
      add_row(psat_pkg::KIND_SECOND, -32768, 32767, 0, 0, 0);
      add_row(psat_pkg::KIND_FINISH, -1, -1, 0, 0, 0);
      // polygon two empty
      add_row(psat_pkg::KIND_NORMAL, 1, 1, 0, 0, 0);
      add_row(psat_pkg::KIND_FIRST, 3, 4, 0, 0, 0);
      add_row(psat_pkg::KIND_FINISH, 0, 0, 1, 0, 0);
      // polygon one empty
      add_row(psat_pkg::KIND_NORMAL, 1, 0, 0, 0, 0);
      add_row(psat_pkg::KIND_SECOND, 1, 1, 0, 0, 0);
      add_row(psat_pkg::KIND_FINISH, 0, 0, 1, 1, 0);
      // both empty, axis stored
      add_row(psat_pkg::KIND_NORMAL, 0, 1, 0, 0, 0);
      add_row(psat_pkg::KIND_FINISH, 0, 0, 1, 1, 0);
      // touching intervals do not separate
      add_row(psat_pkg::KIND_NORMAL, 1, 0, 0, 0, 0);
      add_row(psat_pkg::KIND_FIRST, 5, 0, 0, 0, 0);
      add_row(psat_pkg::KIND_SECOND, 5, 9, 0, 0, 0);
      add_row(psat_pkg::KIND_FINISH, 0, 0, 1, 1, 0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         drive_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

      // first sequence always overfills the axis table
      while (items_accepted < directed_rows.size() + 650) begin
         if (sequence_count > 0 && $urandom_range(9) == 0) send_noise();
         else run_sequence(sequence_count == 0);
      end
      start <= 1'b0;

      guard = 0;
      while (pending_verdicts.size() != 0 && guard < 2000) begin
         @(posedge clock);
         guard++;
      end
      repeat (40) @(posedge clock);
      if (pending_verdicts.size() != 0) begin
         $display("%0d expected result items never arrived", pending_verdicts.size());
         error_count += pending_verdicts.size();
      end

      $display("%0d items in, %0d overlap verdicts checked over %0d random sequences",
               items_accepted, verdicts_checked, sequence_count);
      $display("%0d verdicts collide, %0d flagged dropped normals, %0d errors",
               collide_count, dropped_count, error_count);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
